// ===== src/bht_pkg.sv =====
`default_nettype none

package bht_pkg;

  // Field widths of one request and one response.
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned DEPTH_W   = 8;
  localparam int unsigned BOUND_W   = 2;
  localparam int unsigned GEN_W     = 8;
  localparam int unsigned PAYLOAD_W = 32;

  // Replacement metric: age in the upper byte, inverted depth in the lower byte.
  localparam int unsigned METRIC_W  = GEN_W + DEPTH_W;

  // Operation codes.
  typedef enum logic {
    FUNC_PROBE = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MOD   = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== src/bucketed_hash_table_age_depth.sv =====
`default_nettype none

// Set-associative position table. Each of BUCKETS rows holds WAYS slots and
// lives as one word of a single synchronous memory; a request reads its row,
// the slots are compared in parallel, and a store writes the modified row
// back. A probe returns the first slot whose key matches. A store overwrites
// the matching slot, else the first empty slot (key zero), else the slot with
// the largest age * 256 + (255 - depth), lowest slot on a tie. With BUCKETS a
// power of two the row is read in the transfer cycle, then compared and
// written back. Otherwise the bucket index is produced by folding the key
// down to 32 bits with constant multiplications and then taking the
// remainder by a reciprocal multiplication before the row is read. After
// reset the memory is cleared one row per cycle, and no request is taken
// until the clearing pass is done; generation writes are taken at any time.
module bucketed_hash_table_age_depth #(
  parameter int unsigned WAYS         = 4,
  parameter int unsigned BUCKETS      = 1024,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Generation register
  input  wire logic                           cfg_we_i,
  input  wire logic [bht_pkg::GEN_W-1:0]      cfg_wdata_i,
  // Request channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           func_i,
  input  wire logic [bht_pkg::KEY_W-1:0]      key_i,
  input  wire logic [bht_pkg::DEPTH_W-1:0]    depth_in_i,
  input  wire logic [bht_pkg::BOUND_W-1:0]    bound_in_i,
  input  wire logic [bht_pkg::PAYLOAD_W-1:0]  payload_in_i,
  // Response channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                hit_o,
  output logic [bht_pkg::DEPTH_W-1:0]         depth_out_o,
  output logic [bht_pkg::BOUND_W-1:0]         bound_out_o,
  output logic [bht_pkg::GEN_W-1:0]           gen_out_o,
  output logic [bht_pkg::PAYLOAD_W-1:0]       payload_out_o,
  output logic                                replaced_o
);

  import bht_pkg::*;

  // Only the low PAYLOAD_BITS payload bits, at most 32, can ever reach the table or the response.
  localparam int unsigned SPB     = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int unsigned IW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // Bucket reduction: four folds, a reciprocal step, a subtract, a correction.
  localparam int unsigned FOLDS     = 4;
  localparam int unsigned MOD_STEPS = FOLDS + 3;
  localparam int unsigned SW        = $clog2(MOD_STEPS);
  localparam logic [KEY_W-1:0] BUCKETS_W = KEY_W'(BUCKETS);
  // 2^32 mod BUCKETS and floor(2^32 / BUCKETS).
  localparam logic [31:0] FOLD_C = 32'((64'd1 << 32) % BUCKETS_W);
  localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / BUCKETS_W);

  typedef struct packed {
    logic [KEY_W-1:0]   tag;
    logic [GEN_W-1:0]   gen;
    logic [BOUND_W-1:0] bound;
    logic [DEPTH_W-1:0] depth;
    logic [SPB-1:0]     payload;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  // Control registers
  state_e         state_q, state_d;
  logic [IW-1:0]  clr_q, clr_d;
  logic [GEN_W-1:0] gen_q;

  // Latched request
  func_e              func_q;
  logic [KEY_W-1:0]   key_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [BOUND_W-1:0] bound_q;
  logic [SPB-1:0]     payload_q;
  logic [IW-1:0]      idx_q;

  // Bucket reduction unit
  logic [KEY_W-1:0] mod_q, mod_d;
  logic [SW-1:0]    step_q;
  logic             rem_last;

  // Memory ports
  row_t          bucket_mem [BUCKETS];
  row_t          row_q;
  row_t          wr_row;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] mask_idx;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  // Response registers
  logic               out_valid_q;
  logic               hit_q;
  logic [DEPTH_W-1:0] depth_out_q;
  logic [BOUND_W-1:0] bound_out_q;
  logic [GEN_W-1:0]   gen_out_q;
  logic [SPB-1:0]     payload_out_q;
  logic               replaced_q;

  // Bucket evaluation
  logic          found;
  logic          have_empty;
  logic [WW-1:0] hit_way;
  logic [WW-1:0] empty_way;
  logic [WW-1:0] worst_way;
  logic [WW-1:0] target_way;
  logic          in_xfer;
  logic          eval_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign eval_go    = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);

  // Generation register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (cfg_we_i) begin
      gen_q <= cfg_wdata_i;
    end
  end

  // Bucket index by masking when the bucket count is a power of two.
  assign mask_idx = (BUCKETS == 1) ? '0 : key_i[IW-1:0];

  // Key modulo BUCKETS otherwise. The folds replace the upper half by its
  // weight 2^32 mod BUCKETS until the value fits in 32 bits; the quotient
  // estimate from the reciprocal is at most one short, so one conditional
  // subtract finishes the remainder.
  always_comb begin
    logic [KEY_W-1:0] fold_prod;
    logic [64:0]      recip_prod;
    logic [31:0]      quot_mul;
    fold_prod  = KEY_W'(mod_q[63:32]) * KEY_W'(FOLD_C);
    recip_prod = 65'(mod_q[31:0]) * 65'(RECIP);
    quot_mul   = mod_q[63:32] * BUCKETS_W[31:0];
    priority if (step_q < SW'(FOLDS)) begin
      mod_d = KEY_W'(mod_q[31:0]) + fold_prod;
    end else if (step_q == SW'(FOLDS)) begin
      mod_d = {recip_prod[63:32], mod_q[31:0]};
    end else if (step_q == SW'(FOLDS + 1)) begin
      mod_d = KEY_W'(mod_q[31:0] - quot_mul);
    end else begin
      mod_d = (mod_q >= BUCKETS_W) ? (mod_q - BUCKETS_W) : mod_q;
    end
  end

  assign rem_last = (step_q == SW'(MOD_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (in_xfer) begin
      step_q <= '0;
    end else if (state_q == ST_MOD) begin
      step_q <= step_q + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mod_q <= key_i;
    end else if (state_q == ST_MOD) begin
      mod_q <= mod_d;
    end
  end

  // Row read: at the transfer when masking, else at the last reduction step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mask_idx;
    if (state_q == ST_MOD) begin
      rd_en   = rem_last;
      rd_addr = mod_d[IW-1:0];
    end else if (IS_POW2) begin
      rd_en   = in_xfer;
    end
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q    <= func_e'(func_i);
      key_q     <= key_i;
      depth_q   <= depth_in_i;
      bound_q   <= bound_in_i;
      payload_q <= payload_in_i[SPB-1:0];
    end
    if (rd_en) begin
      idx_q <= rd_addr;
    end
  end

  // Compare all slots of the row that was read.
  always_comb begin
    logic [METRIC_W-1:0] metric;
    logic [METRIC_W-1:0] worst;
    logic [GEN_W-1:0]    age;
    found      = 1'b0;
    have_empty = 1'b0;
    hit_way    = '0;
    empty_way  = '0;
    worst_way  = '0;
    worst      = '0;
    // Descending scan so that the lowest matching or empty slot wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_q[w].tag == key_q) begin
        found   = 1'b1;
        hit_way = WW'(w);
      end
      if (row_q[w].tag == '0) begin
        have_empty = 1'b1;
        empty_way  = WW'(w);
      end
    end
    // Largest metric, ties to the lowest slot.
    for (int w = 0; w < WAYS; w++) begin
      age    = gen_q - row_q[w].gen;
      metric = {age, ~row_q[w].depth};
      if (w == 0 || metric > worst) begin
        worst     = metric;
        worst_way = WW'(w);
      end
    end
  end

  always_comb begin
    priority if (found) begin
      target_way = hit_way;
    end else if (have_empty) begin
      target_way = empty_way;
    end else begin
      target_way = worst_way;
    end
  end

  // Write-back row: zero during the clearing pass, else the updated bucket.
  always_comb begin
    wr_row  = row_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    if (state_q == ST_CLEAR) begin
      wr_row  = '0;
      wr_en   = 1'b1;
      wr_addr = clr_q;
    end else if (eval_go && func_q == FUNC_STORE) begin
      wr_row[target_way] = '{tag: key_q, gen: gen_q, bound: bound_q,
                             depth: depth_q, payload: payload_q};
      wr_en = 1'b1;
    end
  end

  // Bucket memory, one row per word, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bucket_mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      row_q <= bucket_mem[rd_addr];
    end
  end

  // Controller.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = IS_POW2 ? ST_EVAL : ST_MOD;
        end
      end
      ST_MOD: begin
        if (rem_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Response register: a new response loads once the previous one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eval_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eval_go) begin
      hit_q         <= found;
      depth_out_q   <= '0;
      bound_out_q   <= '0;
      gen_out_q     <= '0;
      payload_out_q <= '0;
      replaced_q    <= 1'b0;
      if (func_q == FUNC_PROBE) begin
        if (found) begin
          depth_out_q   <= row_q[hit_way].depth;
          bound_out_q   <= row_q[hit_way].bound;
          gen_out_q     <= row_q[hit_way].gen;
          payload_out_q <= row_q[hit_way].payload;
        end
      end else begin
        // A store that finds neither its key nor an empty slot evicts another key.
        replaced_q <= !found && !have_empty;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign depth_out_o   = depth_out_q;
  assign bound_out_o   = bound_out_q;
  assign gen_out_o     = gen_out_q;
  assign payload_out_o = PAYLOAD_W'(payload_out_q);
  assign replaced_o    = replaced_q;

`ifndef SYNTHESIS
  // An eviction is never reported together with a key match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && replaced_o))
    else $error("response reports both hit and eviction");

  // The memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("bucket memory read and write collide");

  // Evaluation only follows a row read or a stalled evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ($past(rd_en) || $past(state_q == ST_EVAL)))
    else $error("bucket evaluated without a row read");

  // Evicting store responses carry no entry contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && replaced_o) |-> (depth_out_o == '0 && payload_out_o == '0))
    else $error("store response carries entry data");
`endif

endmodule

`default_nettype wire
